### rtl/tvpr_pkg.sv
`timescale 1ns / 1ps

package tvpr_pkg;

    // stream geometry
    localparam int PIXELS_PER_LINE   = 80;
    localparam int LINES_PER_SEGMENT = 60;
    localparam int SEGMENT_COUNT     = 4;
    localparam int ERROR_LIMIT       = 255;
    localparam int CHECK_LINE        = 20;
    localparam int HEADER_BYTES      = 4;
    localparam int PACKET_BYTES      = HEADER_BYTES + 2 * PIXELS_PER_LINE;

    // frame buffer geometry (160x120, four segments of 4800 pixels)
    localparam int BUF_PIXELS        = 19200;
    localparam int LINE_PAIR_PIXELS  = 160;
    localparam int HALF_LINE_PIXELS  = 80;
    localparam int SEG_PIXELS        = 4800;
    localparam int BUF_LAST          = BUF_PIXELS - 1;

    localparam int POS_W   = $clog2(PACKET_BYTES);
    localparam int COL_W   = $clog2(PIXELS_PER_LINE);
    localparam int LINE_W  = 6;
    localparam int SEG_W   = 3;
    localparam int SIDX_W  = 2;
    localparam int ERR_W   = 8;
    localparam int ADDR_W  = 15;
    localparam int PIX_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic REG_VERTICAL_ROTATION = 1'b0;
    localparam logic REG_HORIZONTAL_MIRROR = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_DISCARD      = 3'd1,
        ST_LINE         = 3'd2,
        ST_SEG_ZERO     = 3'd3,
        ST_SEG_MISMATCH = 3'd4,
        ST_ZERO_PIXEL   = 3'd5
    } status_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic              we;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [SIDX_W-1:0] seg_idx;
        logic [PIX_W-1:0]  pixel;
        logic              done;
        status_t           status;
        logic              frame_done;
        logic              resync;
    } cmd_t;

    typedef struct packed {
        logic vertical_rotation;
        logic horizontal_mirror;
    } cfg_t;

endpackage

### rtl/tvpr_front.sv
`timescale 1ns / 1ps

module tvpr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    output logic                 push,
    output tvpr_pkg::cmd_t       cmd
);
    import tvpr_pkg::*;

    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [LINE_W-1:0] line_reg,   line_next;
    logic [SEG_W-1:0]  seg_reg,    seg_next;
    logic [ERR_W-1:0]  err_reg,    err_next;
    logic [3:0]        nibble_reg, nibble_next;
    status_t           pend_reg,   pend_next;
    logic [7:0]        hi_reg,     hi_next;

    logic [LINE_W-1:0] line_inc;
    logic [ERR_W-1:0]  err_inc;
    logic [PIX_W-1:0]  pix_val;
    logic [POS_W-1:0]  pix_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            line_reg   <= '0;
            seg_reg    <= SEG_W'(1);
            err_reg    <= '0;
            nibble_reg <= '0;
            pend_reg   <= ST_OK;
            hi_reg     <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            seg_reg    <= seg_next;
            err_reg    <= err_next;
            nibble_reg <= nibble_next;
            pend_reg   <= pend_next;
            hi_reg     <= hi_next;
        end
    end

    assign line_inc = line_reg + LINE_W'(1);
    assign err_inc  = err_reg + ERR_W'(1);
    assign pix_val  = {hi_reg, data_byte};
    assign pix_pos  = (pos_reg - POS_W'(HEADER_BYTES)) >> 1;

    always_comb
    begin
        pos_next    = pos_reg;
        line_next   = line_reg;
        seg_next    = seg_reg;
        err_next    = err_reg;
        nibble_next = nibble_reg;
        pend_next   = pend_reg;
        hi_next     = hi_reg;

        cmd         = '0;
        cmd.status  = ST_OK;
        cmd.line    = line_reg;
        cmd.seg_idx = SIDX_W'(seg_reg - SEG_W'(1));

        if (accept)
        begin
            // header and pixel classification
            if (pos_reg == POS_W'(0))
            begin
                nibble_next = data_byte[7:4];
                pend_next   = (data_byte[3:0] == 4'hF) ? ST_DISCARD : ST_OK;
            end
            else if (pos_reg == POS_W'(1))
            begin
                if (pend_reg == ST_OK)
                begin
                    if (data_byte != 8'(line_reg))
                        pend_next = ST_LINE;
                    else if (line_reg == LINE_W'(CHECK_LINE))
                    begin
                        if (nibble_reg == 4'd0)
                            pend_next = ST_SEG_ZERO;
                        else if (nibble_reg != 4'(seg_reg))
                            pend_next = ST_SEG_MISMATCH;
                    end
                end
            end
            else if (pos_reg >= POS_W'(HEADER_BYTES))
            begin
                if (!pos_reg[0])
                    hi_next = data_byte;
                else if (pend_reg == ST_OK)
                begin
                    if (pix_val == '0)
                        pend_next = ST_ZERO_PIXEL;
                    else
                    begin
                        cmd.we    = 1'b1;
                        cmd.col   = COL_W'(pix_pos);
                        cmd.pixel = pix_val;
                    end
                end
            end

            // end of packet bookkeeping
            if (pos_reg == POS_W'(PACKET_BYTES - 1))
            begin
                cmd.done   = 1'b1;
                cmd.status = pend_next;
                pos_next   = '0;
                if (pend_next == ST_OK)
                begin
                    line_next = line_inc;
                    if (line_inc >= LINE_W'(LINES_PER_SEGMENT))
                    begin
                        line_next = '0;
                        err_next  = '0;
                        if (seg_reg >= SEG_W'(SEGMENT_COUNT))
                        begin
                            cmd.frame_done = 1'b1;
                            seg_next       = SEG_W'(1);
                        end
                        else
                            seg_next = seg_reg + SEG_W'(1);
                    end
                end
                else
                begin
                    line_next = '0;
                    err_next  = err_inc;
                    if (err_inc >= ERR_W'(ERROR_LIMIT))
                    begin
                        err_next   = '0;
                        seg_next   = SEG_W'(1);
                        cmd.resync = 1'b1;
                    end
                end
                pend_next = ST_OK;
            end
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    assign push = accept && (cmd.we || cmd.done);

endmodule

### rtl/tvpr_queue.sv
`timescale 1ns / 1ps

module tvpr_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tvpr_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tvpr_pkg::cmd_t   head_cmd
);
    import tvpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/tvpr_back.sv
`timescale 1ns / 1ps

module tvpr_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tvpr_pkg::cfg_t                cfg,
    input  logic                          head_valid,
    input  tvpr_pkg::cmd_t                head_cmd,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          write_enable,
    output logic [tvpr_pkg::ADDR_W-1:0]   write_address,
    output logic [tvpr_pkg::PIX_W-1:0]    pixel_value,
    output logic                          packet_done,
    output logic [2:0]                    packet_status,
    output logic                          frame_done,
    output logic                          resync_request
);
    import tvpr_pkg::*;

    logic              valid_reg;
    logic              we_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              done_reg;
    status_t           status_reg;
    logic              fd_reg;
    logic              rs_reg;

    logic [COL_W-1:0]  col;
    logic              half;
    logic [ADDR_W-1:0] seg_base;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] addr_next;

    // buffer address for this pixel
    always_comb
    begin
        col  = cfg.horizontal_mirror ? COL_W'(PIXELS_PER_LINE - 1) - head_cmd.col
                                     : head_cmd.col;
        half = head_cmd.line[0];
        if (!cfg.vertical_rotation && cfg.horizontal_mirror)
            half = !half;
        seg_base = ADDR_W'(head_cmd.seg_idx) * ADDR_W'(SEG_PIXELS);
        offset   = ADDR_W'(head_cmd.line >> 1) * ADDR_W'(LINE_PAIR_PIXELS)
                 + (half ? ADDR_W'(HALF_LINE_PIXELS) : ADDR_W'(0))
                 + ADDR_W'(col);
        if (!head_cmd.we)
            addr_next = '0;
        else if (cfg.vertical_rotation)
            addr_next = seg_base + offset;
        else
            addr_next = ADDR_W'(BUF_LAST) - seg_base - offset;
    end

    assign pop = head_valid && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            we_reg     <= head_cmd.we;
            addr_reg   <= addr_next;
            pix_reg    <= head_cmd.pixel;
            done_reg   <= head_cmd.done;
            status_reg <= head_cmd.status;
            fd_reg     <= head_cmd.frame_done;
            rs_reg     <= head_cmd.resync;
        end
    end

    assign out_valid      = valid_reg;
    assign write_enable   = we_reg;
    assign write_address  = addr_reg;
    assign pixel_value    = pix_reg;
    assign packet_done    = done_reg;
    assign packet_status  = status_reg;
    assign frame_done     = fd_reg;
    assign resync_request = rs_reg;

endmodule

### rtl/thermal_video_packet_reassembler.sv
`timescale 1ns / 1ps

// segmented thermal video packet reassembler: takes the link one byte per
// transaction, at a sustained rate of one byte per clock while in_stall is
// low. each 164-byte packet (id, ignored crc, 80 big-endian pixels) is
// checked for discard code, line number and, at line 20, segment number;
// nonzero pixels of a good packet come out as frame buffer writes at a
// 160x120 address set by the rotation and mirror registers, and the last
// byte of every packet yields a transaction carrying packet_done and the
// packet status. a byte that neither writes a pixel nor ends a packet yields
// nothing. the front end classifies the byte combinationally and writes the
// transaction into a two-entry queue at the edge that takes the byte; from
// the queue head it moves into the output register once that register is
// empty or not stalled. the queue lets the input keep flowing while fewer
// than two results wait in it behind a stalled output; a longer output stall
// backs up into in_stall. configuration writes must only happen while idle.
module thermal_video_packet_reassembler
(
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write port
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic                          cfg_data,

    // byte input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          write_enable,
    output logic [tvpr_pkg::ADDR_W-1:0]   write_address,
    output logic [tvpr_pkg::PIX_W-1:0]    pixel_value,
    output logic                          packet_done,
    output logic [2:0]                    packet_status,
    output logic                          frame_done,
    output logic                          resync_request
);
    import tvpr_pkg::*;

    cfg_t  cfg_reg;
    logic  accept;
    logic  push;
    cmd_t  push_cmd;
    logic  q_full;
    logic  q_valid;
    cmd_t  q_cmd;
    logic  pop;

    // mode registers, only bit 0 of the data matters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERTICAL_ROTATION: cfg_reg.vertical_rotation <= cfg_data;
                REG_HORIZONTAL_MIRROR: cfg_reg.horizontal_mirror <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end takes a byte whenever the queue has room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    tvpr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    tvpr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // back end forms the buffer address and holds the output transaction
    tvpr_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head_valid     (q_valid),
        .head_cmd       (q_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .write_enable   (write_enable),
        .write_address  (write_address),
        .pixel_value    (pixel_value),
        .packet_done    (packet_done),
        .packet_status  (packet_status),
        .frame_done     (frame_done),
        .resync_request (resync_request)
    );

endmodule
